@@ hw/rtl/sam_pkg.sv @@
package sam_pkg;

    // Default values of the top-level parameters.
    localparam int TICK_BITS_DEF      = 32;
    localparam int BUTTON_HOLDOFF_DEF = 500;
    localparam int REPORT_BITS_DEF    = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_LOW_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEMP_HIGH_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_LIMIT      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Z_OFFSET        = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_PERIOD    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLINK_PERIOD    = 3'd7;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values.
    localparam logic [15:0] LIGHT_LOW_LIMIT_RST = 16'd50;
    localparam logic [11:0] TEMP_HIGH_LIMIT_RST = 12'd260;
    localparam logic [7:0]  MOVE_LIMIT_RST      = 8'd15;
    localparam logic [15:0] DIGIT_PERIOD_RST    = 16'd1000;
    localparam logic [15:0] BLINK_PERIOD_RST    = 16'd333;

    // Display and LED codes.
    localparam logic [4:0] BLANK_CODE = 5'd16;
    localparam logic [3:0] SAMPLE_DIGIT_A = 4'd5;
    localparam logic [3:0] SAMPLE_DIGIT_B = 4'd10;
    localparam logic [3:0] REPORT_DIGIT   = 4'd15;
    localparam logic [1:0] LED_OFF  = 2'b00;
    localparam logic [1:0] LED_RED  = 2'b01;
    localparam logic [1:0] LED_BLUE = 2'b10;
    localparam logic [1:0] LED_BOTH = 2'b11;

    // Warning levels.
    localparam logic [1:0] WARN_NONE      = 2'd0;
    localparam logic [1:0] WARN_DARK_MOVE = 2'd1;
    localparam logic [1:0] WARN_HOT       = 2'd2;
    localparam logic [1:0] WARN_BOTH      = 2'd3;

    typedef struct packed {
        logic              button_level;
        logic [15:0]       light_level;
        logic [11:0]       temp_tenths;
        logic signed [7:0] raw_x;
        logic signed [7:0] raw_y;
        logic signed [7:0] raw_z;
    } sam_in_t;

    typedef struct packed {
        logic              monitor_on;
        logic              digit_write;
        logic [4:0]        digit_code;
        logic [1:0]        led_mask;
        logic [1:0]        warn_level;
        logic              sample_strobe;
        logic              report_strobe;
        logic [15:0]       report_number;
        logic signed [7:0] accel_x;
        logic signed [7:0] accel_y;
        logic signed [7:0] accel_z;
        logic              entered_monitor;
    } sam_out_t;

    typedef struct packed {
        logic [15:0]       light_low_limit;
        logic [11:0]       temp_high_limit;
        logic [7:0]        move_limit;
        logic signed [7:0] x_offset;
        logic signed [7:0] y_offset;
        logic signed [7:0] z_offset;
        logic [15:0]       digit_period;
        logic [15:0]       blink_period;
    } sam_cfg_t;

endpackage

@@ hw/rtl/sensor_alarm_monitor.sv @@
// Two-mode sensor alarm. Each tick transaction carries one millisecond of the
// mode button level and the light, temperature and raw acceleration readings,
// and yields exactly one result transaction. A press of the active-low button,
// taken at most once per BUTTON_HOLDOFF ticks, toggles between stable mode
// (display blanked and LEDs dark once on entry) and monitor mode, which
// flags its entry, steps a hex digit every digit_period ticks, samples the
// offset-corrected axes on digits 5, 10 and 15, and on digit 15 classifies
// movement in the dark and heat into a warning and issues a numbered report.
// A standing warning blinks the LEDs every blink_period ticks. The block takes
// one tick transaction per clock cycle unless tick_stall holds it: a tick
// passes an input register, a combinational update against the state
// registers, and a result register, from which its result is offered. The
// result register frees itself in the cycle it is taken, so the input side
// stalls only while a finished result waits to be taken and the input
// register is already full. Configuration writes are always ready and must
// be issued only while no tick is in flight.
module sensor_alarm_monitor #(
    parameter int TICK_BITS      = sam_pkg::TICK_BITS_DEF,
    parameter int BUTTON_HOLDOFF = sam_pkg::BUTTON_HOLDOFF_DEF,
    parameter int REPORT_BITS    = sam_pkg::REPORT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  sam_pkg::sam_in_t                    tick_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output sam_pkg::sam_out_t                   res_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sam_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import sam_pkg::*;

    sam_cfg_t cfg;
    sam_in_t  item;
    sam_out_t result;
    logic     item_valid;
    logic     out_free;
    logic     advance;

    // The update for the held tick runs in the same cycle it leaves the
    // input register, so the input register reloads whenever it is empty
    // or its tick moves on.
    assign advance    = item_valid && out_free;
    assign tick_stall = item_valid && !out_free;
    assign cfg_ready  = 1'b1;

    sam_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sam_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (!tick_stall),
        .tick_valid (tick_valid),
        .tick_data  (tick_data),
        .item_valid (item_valid),
        .item       (item)
    );

    // All mode, display, sampling, warning and blink state lives here and
    // advances once per transaction.
    sam_core #(
        .TICK_BITS      (TICK_BITS),
        .BUTTON_HOLDOFF (BUTTON_HOLDOFF),
        .REPORT_BITS    (REPORT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    sam_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_data  (res_data),
        .free      (out_free)
    );

endmodule

@@ hw/rtl/sam_cfg_regs.sv @@
module sam_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [sam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output sam_pkg::sam_cfg_t                   cfg
);
    import sam_pkg::*;

    sam_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_low_limit <= LIGHT_LOW_LIMIT_RST;
            cfg_reg.temp_high_limit <= TEMP_HIGH_LIMIT_RST;
            cfg_reg.move_limit      <= MOVE_LIMIT_RST;
            cfg_reg.x_offset        <= '0;
            cfg_reg.y_offset        <= '0;
            cfg_reg.z_offset        <= '0;
            cfg_reg.digit_period    <= DIGIT_PERIOD_RST;
            cfg_reg.blink_period    <= BLINK_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIGHT_LOW_LIMIT: cfg_reg.light_low_limit <= cfg_data;
                REG_TEMP_HIGH_LIMIT: cfg_reg.temp_high_limit <= cfg_data[11:0];
                REG_MOVE_LIMIT:      cfg_reg.move_limit      <= cfg_data[7:0];
                REG_X_OFFSET:        cfg_reg.x_offset        <= cfg_data[7:0];
                REG_Y_OFFSET:        cfg_reg.y_offset        <= cfg_data[7:0];
                REG_Z_OFFSET:        cfg_reg.z_offset        <= cfg_data[7:0];
                REG_DIGIT_PERIOD:    cfg_reg.digit_period    <= cfg_data;
                REG_BLINK_PERIOD:    cfg_reg.blink_period    <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/sam_in_stage.sv @@
module sam_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              tick_valid,
    input  sam_pkg::sam_in_t  tick_data,
    output logic              item_valid,
    output sam_pkg::sam_in_t  item
);
    import sam_pkg::*;

    logic    valid_reg;
    sam_in_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= tick_valid;
        end
    end

    // Payload is captured only with a new transaction.
    always_ff @(posedge clk)
    begin
        if (load && tick_valid)
        begin
            item_reg <= tick_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/sam_core.sv @@
module sam_core #(
    parameter int TICK_BITS      = sam_pkg::TICK_BITS_DEF,
    parameter int BUTTON_HOLDOFF = sam_pkg::BUTTON_HOLDOFF_DEF,
    parameter int REPORT_BITS    = sam_pkg::REPORT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  sam_pkg::sam_in_t   item,
    input  sam_pkg::sam_cfg_t  cfg,
    output sam_pkg::sam_out_t  result
);
    import sam_pkg::*;

    localparam logic [TICK_BITS-1:0] HOLDOFF_TICKS = TICK_BITS'(BUTTON_HOLDOFF);

    logic [TICK_BITS-1:0]   tick_reg, tick_next;
    logic [TICK_BITS-1:0]   press_reg, press_next;
    logic [TICK_BITS-1:0]   digit_time_reg, digit_time_next;
    logic [TICK_BITS-1:0]   blink_time_reg, blink_time_next;
    logic                   mode_reg, mode_next;
    logic                   cleared_reg, cleared_next;
    logic                   announced_reg, announced_next;
    logic [3:0]             digit_index_reg, digit_index_next;
    logic                   blink_on_reg, blink_on_next;
    logic [1:0]             led_reg, led_next;
    logic [1:0]             warn_reg, warn_next;
    logic signed [7:0]      cur_reg [3];
    logic signed [7:0]      cur_next [3];
    logic signed [7:0]      prev_reg [3];
    logic signed [7:0]      prev_next [3];
    logic [REPORT_BITS-1:0] report_reg, report_next;

    logic signed [7:0]      raw [3];
    logic signed [7:0]      offset [3];
    logic [31:0]            report_wide;

    assign raw[0]    = item.raw_x;
    assign raw[1]    = item.raw_y;
    assign raw[2]    = item.raw_z;
    assign offset[0] = cfg.x_offset;
    assign offset[1] = cfg.y_offset;
    assign offset[2] = cfg.z_offset;
    assign report_wide = 32'(report_reg);

    always_comb
    begin
        logic [3:0]        shown;
        logic              moved;
        logic              hot;
        logic              dark_move;
        logic signed [8:0] diff;
        logic [8:0]        mag;
        logic [1:0]        colour;

        tick_next        = tick_reg + 1'b1;
        press_next       = press_reg;
        digit_time_next  = digit_time_reg;
        blink_time_next  = blink_time_reg;
        mode_next        = mode_reg;
        cleared_next     = cleared_reg;
        announced_next   = announced_reg;
        digit_index_next = digit_index_reg;
        blink_on_next    = blink_on_reg;
        led_next         = led_reg;
        warn_next        = warn_reg;
        report_next      = report_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        shown            = digit_index_reg;
        moved            = 1'b0;
        hot              = 1'b0;
        dark_move        = 1'b0;
        diff             = '0;
        mag              = '0;
        colour           = LED_OFF;
        result           = '0;

        // A press toggles the mode once the holdoff since the last press has run out.
        if (!item.button_level && (tick_next - press_reg) >= HOLDOFF_TICKS)
        begin
            press_next = tick_next;
            mode_next  = !mode_reg;
            if (mode_reg)
            begin
                cleared_next = 1'b0;
            end
        end

        if (!mode_next)
        begin
            if (!cleared_next)
            begin
                result.digit_write = 1'b1;
                result.digit_code  = BLANK_CODE;
                digit_index_next   = '0;
                led_next           = LED_OFF;
                cleared_next       = 1'b1;
                announced_next     = 1'b0;
            end
        end
        else
        begin
            if (!announced_reg)
            begin
                result.entered_monitor = 1'b1;
                announced_next         = 1'b1;
                cleared_next           = 1'b0;
            end

            if ((tick_next - digit_time_reg) >= TICK_BITS'(cfg.digit_period))
            begin
                digit_time_next    = tick_next;
                result.digit_write = 1'b1;
                result.digit_code  = {1'b0, shown};
                digit_index_next   = shown + 1'b1;

                if (shown == SAMPLE_DIGIT_A || shown == SAMPLE_DIGIT_B ||
                    shown == REPORT_DIGIT)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cur_next[i] = raw[i] + offset[i];
                    end
                    result.sample_strobe = 1'b1;
                end

                if (shown == REPORT_DIGIT)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        diff = {cur_next[i][7], cur_next[i]} - {prev_reg[i][7], prev_reg[i]};
                        mag  = diff[8] ? 9'(-diff) : 9'(diff);
                        if (mag > {1'b0, cfg.move_limit})
                        begin
                            moved = 1'b1;
                        end
                        prev_next[i] = cur_next[i];
                    end
                    hot       = item.temp_tenths > cfg.temp_high_limit;
                    dark_move = moved && (item.light_level < cfg.light_low_limit);
                    warn_next = {hot, dark_move};
                    result.report_strobe = 1'b1;
                    result.report_number = report_wide[15:0];
                    report_next          = report_reg + 1'b1;
                end
            end

            if (warn_next != WARN_NONE)
            begin
                if ((tick_next - blink_time_reg) >= TICK_BITS'(cfg.blink_period))
                begin
                    case (warn_next)
                        WARN_BOTH:      colour = LED_BOTH;
                        WARN_HOT:       colour = LED_RED;
                        WARN_DARK_MOVE: colour = LED_BLUE;
                        default:        colour = LED_OFF;
                    endcase
                    blink_time_next = tick_next;
                    blink_on_next   = !blink_on_reg;
                    led_next        = blink_on_next ? colour : LED_OFF;
                end
            end
            else
            begin
                led_next = LED_OFF;
            end
        end

        result.monitor_on = mode_next;
        result.led_mask   = led_next;
        result.warn_level = warn_next;
        result.accel_x    = cur_next[0];
        result.accel_y    = cur_next[1];
        result.accel_z    = cur_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            press_reg       <= '0;
            digit_time_reg  <= '0;
            blink_time_reg  <= '0;
            mode_reg        <= 1'b0;
            cleared_reg     <= 1'b0;
            announced_reg   <= 1'b0;
            digit_index_reg <= '0;
            blink_on_reg    <= 1'b0;
            led_reg         <= LED_OFF;
            warn_reg        <= WARN_NONE;
            report_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            tick_reg        <= tick_next;
            press_reg       <= press_next;
            digit_time_reg  <= digit_time_next;
            blink_time_reg  <= blink_time_next;
            mode_reg        <= mode_next;
            cleared_reg     <= cleared_next;
            announced_reg   <= announced_next;
            digit_index_reg <= digit_index_next;
            blink_on_reg    <= blink_on_next;
            led_reg         <= led_next;
            warn_reg        <= warn_next;
            report_reg      <= report_next;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]  <= cur_next[i];
                prev_reg[i] <= prev_next[i];
            end
        end
    end

endmodule

@@ hw/rtl/sam_out_stage.sv @@
module sam_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sam_pkg::sam_out_t  result,
    input  logic               res_stall,
    output logic               res_valid,
    output sam_pkg::sam_out_t  res_data,
    output logic               free
);
    import sam_pkg::*;

    logic     valid_reg;
    sam_out_t data_reg;

    // The register can take a new result when it is empty or being drained.
    assign free = !valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

@@ tb/sv/sam_checker.sv @@
`timescale 1ns / 100ps

module sam_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    input  logic                                tick_stall,
    input  sam_pkg::sam_in_t                    tick_data,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  sam_pkg::sam_out_t                   res_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  error_count,
    output int                                  results_owed
);
    import sam_pkg::*;

    localparam int TICK_W   = TICK_BITS_DEF;
    localparam int HOLDOFF  = BUTTON_HOLDOFF_DEF;
    localparam int REPORT_W = REPORT_BITS_DEF;

    // Shadow of the configuration registers and of the alarm state.
    sam_cfg_t            regs;
    logic [TICK_W-1:0]   tick_now;
    logic [TICK_W-1:0]   press_tick;
    logic [TICK_W-1:0]   digit_tick;
    logic [TICK_W-1:0]   blink_tick;
    logic                monitor_mode;
    logic                blanked;
    logic                announced;
    logic                blink_lit;
    logic [3:0]          next_digit;
    logic [1:0]          led_now;
    logic [1:0]          warn_now;
    logic [7:0]          axes_now [3];
    logic [7:0]          axes_last [3];
    logic [REPORT_W-1:0] report_seq;

    sam_out_t alarm_results_q [$];

    // Advances the alarm by one millisecond tick and returns what it shows.
    task automatic advance_alarm_tick(input sam_in_t t, output sam_out_t r);
        logic [7:0]        raw [3];
        logic [7:0]        offs [3];
        logic [TICK_W-1:0] since;
        logic [3:0]        shown;
        logic              moved;
        logic [1:0]        colour;
        int                delta;
        raw[0]  = t.raw_x;
        raw[1]  = t.raw_y;
        raw[2]  = t.raw_z;
        offs[0] = regs.x_offset;
        offs[1] = regs.y_offset;
        offs[2] = regs.z_offset;
        r = '0;

        tick_now = tick_now + 1'b1;
        since = tick_now - press_tick;
        if (!t.button_level && since >= HOLDOFF)
        begin
            press_tick = tick_now;
            monitor_mode = !monitor_mode;
            if (!monitor_mode)
                blanked = 1'b0;
        end

        if (!monitor_mode)
        begin
            if (!blanked)
            begin
                r.digit_write = 1'b1;
                r.digit_code  = BLANK_CODE;
                next_digit    = '0;
                led_now       = LED_OFF;
                blanked       = 1'b1;
                announced     = 1'b0;
            end
        end
        else
        begin
            if (!announced)
            begin
                r.entered_monitor = 1'b1;
                announced = 1'b1;
                blanked   = 1'b0;
            end
            since = tick_now - digit_tick;
            if (since >= regs.digit_period)
            begin
                shown = next_digit;
                digit_tick = tick_now;
                r.digit_write = 1'b1;
                r.digit_code  = {1'b0, shown};
                next_digit = shown + 1'b1;
                if (shown == SAMPLE_DIGIT_A || shown == SAMPLE_DIGIT_B ||
                    shown == REPORT_DIGIT)
                begin
                    for (int i = 0; i < 3; i++)
                        axes_now[i] = raw[i] + offs[i];
                    r.sample_strobe = 1'b1;
                end
                if (shown == REPORT_DIGIT)
                begin
                    // Movement uses the full signed change of each axis.
                    moved = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        delta = int'($signed(axes_now[i])) - int'($signed(axes_last[i]));
                        if (delta < 0)
                            delta = -delta;
                        if (delta > int'(regs.move_limit))
                            moved = 1'b1;
                        axes_last[i] = axes_now[i];
                    end
                    warn_now = WARN_NONE;
                    if (t.temp_tenths > regs.temp_high_limit)
                        warn_now = warn_now | WARN_HOT;
                    if (moved && t.light_level < regs.light_low_limit)
                        warn_now = warn_now | WARN_DARK_MOVE;
                    r.report_strobe = 1'b1;
                    r.report_number = report_seq[15:0];
                    report_seq = report_seq + 1'b1;
                end
            end
            if (warn_now != WARN_NONE)
            begin
                since = tick_now - blink_tick;
                if (since >= regs.blink_period)
                begin
                    case (warn_now)
                        WARN_BOTH: colour = LED_BOTH;
                        WARN_HOT:  colour = LED_RED;
                        default:   colour = LED_BLUE;
                    endcase
                    blink_tick = tick_now;
                    blink_lit = !blink_lit;
                    led_now = blink_lit ? colour : LED_OFF;
                end
            end
            else
            begin
                led_now = LED_OFF;
            end
        end

        r.monitor_on = monitor_mode;
        r.led_mask   = led_now;
        r.warn_level = warn_now;
        r.accel_x    = axes_now[0];
        r.accel_y    = axes_now[1];
        r.accel_z    = axes_now[2];
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        sam_out_t want;
        sam_out_t fresh;
        if (!rst_n)
        begin
            regs.light_low_limit = LIGHT_LOW_LIMIT_RST;
            regs.temp_high_limit = TEMP_HIGH_LIMIT_RST;
            regs.move_limit      = MOVE_LIMIT_RST;
            regs.x_offset        = '0;
            regs.y_offset        = '0;
            regs.z_offset        = '0;
            regs.digit_period    = DIGIT_PERIOD_RST;
            regs.blink_period    = BLINK_PERIOD_RST;
            tick_now     = '0;
            press_tick   = '0;
            digit_tick   = '0;
            blink_tick   = '0;
            monitor_mode = 1'b0;
            blanked      = 1'b0;
            announced    = 1'b0;
            blink_lit    = 1'b0;
            next_digit   = '0;
            led_now      = LED_OFF;
            warn_now     = WARN_NONE;
            report_seq   = '0;
            for (int i = 0; i < 3; i++)
            begin
                axes_now[i]  = '0;
                axes_last[i] = '0;
            end
            alarm_results_q.delete();
            error_count  = 0;
            results_owed = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (alarm_results_q.size() == 0)
                begin
                    $error("result transaction with no tick waiting for it");
                    error_count++;
                end
                else
                begin
                    want = alarm_results_q.pop_front();
                    compare_field("monitor_on", 16'(want.monitor_on),
                                  16'(res_data.monitor_on));
                    compare_field("digit_write", 16'(want.digit_write),
                                  16'(res_data.digit_write));
                    compare_field("digit_code", 16'(want.digit_code),
                                  16'(res_data.digit_code));
                    compare_field("led_mask", 16'(want.led_mask),
                                  16'(res_data.led_mask));
                    compare_field("warn_level", 16'(want.warn_level),
                                  16'(res_data.warn_level));
                    compare_field("sample_strobe", 16'(want.sample_strobe),
                                  16'(res_data.sample_strobe));
                    compare_field("report_strobe", 16'(want.report_strobe),
                                  16'(res_data.report_strobe));
                    compare_field("report_number", want.report_number,
                                  res_data.report_number);
                    compare_field("accel_x", 16'(want.accel_x), 16'(res_data.accel_x));
                    compare_field("accel_y", 16'(want.accel_y), 16'(res_data.accel_y));
                    compare_field("accel_z", 16'(want.accel_z), 16'(res_data.accel_z));
                    compare_field("entered_monitor", 16'(want.entered_monitor),
                                  16'(res_data.entered_monitor));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LIGHT_LOW_LIMIT: regs.light_low_limit = cfg_data;
                    REG_TEMP_HIGH_LIMIT: regs.temp_high_limit = cfg_data[11:0];
                    REG_MOVE_LIMIT:      regs.move_limit      = cfg_data[7:0];
                    REG_X_OFFSET:        regs.x_offset        = cfg_data[7:0];
                    REG_Y_OFFSET:        regs.y_offset        = cfg_data[7:0];
                    REG_Z_OFFSET:        regs.z_offset        = cfg_data[7:0];
                    REG_DIGIT_PERIOD:    regs.digit_period    = cfg_data;
                    REG_BLINK_PERIOD:    regs.blink_period    = cfg_data;
                    default: ;
                endcase
            end

            if (tick_valid && !tick_stall)
            begin
                advance_alarm_tick(tick_data, fresh);
                alarm_results_q.push_back(fresh);
            end

            results_owed = alarm_results_q.size();
        end
    end

endmodule

@@ tb/sv/tb_sensor_alarm_monitor.sv @@
`timescale 1ns / 100ps

module tb_sensor_alarm_monitor;
    import sam_pkg::*;

    // Run shape. Each phase reprograms every register while the block is idle
    // and then feeds a run of tick transactions.
    localparam int PHASE_COUNT     = 11;
    localparam int TICKS_PER_PHASE = 120;
    localparam int DIRECTED_TICKS  = 20;
    localparam int HOLDOFF         = BUTTON_HOLDOFF_DEF;
    // The long receiver hold-off starts once this many ticks went in.
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 120;
    // The limit is meant to stay above the longest run, with maximal gaps and
    // stalls.
    localparam int CYCLE_LIMIT     = 500000;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       tick_valid = 1'b0;
    logic                       tick_stall;
    sam_in_t                    tick_data  = '0;
    logic                       res_valid;
    logic                       res_stall  = 1'b0;
    sam_out_t                   res_data;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data   = '0;

    int error_count;
    int results_owed;
    int cycle_count = 0;

    // Sender bookkeeping. The button rule is simple enough to follow here, so
    // the stimulus knows which mode the block is in and can steer the mode
    // changes: leave stable mode quickly, stay in monitor mode for a while.
    int         ticks_sent    = 0;
    int         last_press    = 0;
    logic       monitor_guess = 1'b0;
    logic [7:0] base_axis [3];
    logic [15:0] light_cfg    = LIGHT_LOW_LIMIT_RST;
    logic [11:0] temp_cfg     = TEMP_HIGH_LIMIT_RST;
    logic [7:0]  move_cfg     = MOVE_LIMIT_RST;

    always #5 clk = ~clk;

    sensor_alarm_monitor u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_data  (tick_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    sam_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick_data    (tick_data),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_data     (res_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sensor_alarm_monitor: errors");
            $finish;
        end
    end

    // Builds one tick. Sensor readings cluster around the programmed limits
    // so that "dark", "hot" and "moved" flip often, with the exact limit
    // values included, and now and then a reading is fully random.
    function automatic sam_in_t make_tick();
        sam_in_t    t;
        int         n;
        int         spread;
        int         pick;
        logic       press;
        n = ticks_sent + 1;
        if (n - last_press >= HOLDOFF)
            press = monitor_guess ? ($urandom_range(0, 39) == 0)
                                  : ($urandom_range(0, 2) == 0);
        else
            press = ($urandom_range(0, 24) == 0);   // ignored, still in hold-off
        t.button_level = !press;

        if ($urandom_range(0, 3) == 0)
            t.light_level = 16'($urandom);
        else
            t.light_level = 16'(light_cfg + $urandom_range(0, 6) - 3);
        if ($urandom_range(0, 3) == 0)
            t.temp_tenths = 12'($urandom);
        else
            t.temp_tenths = 12'(temp_cfg + $urandom_range(0, 6) - 3);

        // Mostly a steady board with a little jitter, sometimes a change close
        // to the movement limit, sometimes a violent shake.
        pick = $urandom_range(0, 9);
        if (pick < 5)
            spread = 2;
        else if (pick < 8)
            spread = int'(move_cfg) + 2;
        else
            spread = 128;
        if ($urandom_range(0, 19) == 0)
            base_axis[$urandom_range(0, 2)] = 8'($urandom);
        t.raw_x = 8'(base_axis[0] + $urandom_range(0, 2 * spread) - spread);
        t.raw_y = 8'(base_axis[1] + $urandom_range(0, 2 * spread) - spread);
        t.raw_z = 8'(base_axis[2] + $urandom_range(0, 2 * spread) - spread);
        return t;
    endfunction

    // Offers one tick transaction, holds it until accepted, then idles for a
    // random gap when gaps are enabled. With no gap, valid simply stays high.
    task automatic send_tick(input sam_in_t t, input logic gappy);
        int gap;
        int pick;
        @(negedge clk);
        tick_valid <= 1'b1;
        tick_data  <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        ticks_sent++;
        if (!t.button_level && ticks_sent - last_press >= HOLDOFF)
        begin
            last_press = ticks_sent;
            monitor_guess = !monitor_guess;
        end
        gap = 0;
        if (gappy)
        begin
            pick = $urandom_range(0, 19);
            if (pick >= 18)
                gap = $urandom_range(8, 30);
            else if (pick >= 10)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            tick_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Writes one register. Bits above the register's width carry noise,
    // which the block has to drop.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [15:0] value, input int width);
        logic [15:0] word;
        word = value;
        for (int b = width; b < CFG_DATA_BITS; b++)
            word[b] = 1'($urandom_range(0, 1));
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Result side: random stalls, mostly short, a few long, with free
    // stretches in between. Once, early in the run, the receiver holds off
    // for a long stretch while ticks keep coming, so both pipeline registers
    // fill and the tick channel has to stall.
    initial
    begin : result_side
        logic held_off;
        int   pick;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && ticks_sent >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1)
                    @(negedge clk);
                @(negedge clk);
                res_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    @(negedge clk);
                    res_stall <= 1'b0;
                    repeat ($urandom_range(10, 40) - 1)
                        @(negedge clk);
                end
                else if (pick == 9)
                begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                    repeat ($urandom_range(8, 30) - 1)
                        @(negedge clk);
                end
                else
                begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                    repeat ($urandom_range(1, 3) - 1)
                        @(negedge clk);
                    @(negedge clk);
                    res_stall <= 1'b0;
                    repeat ($urandom_range(1, 4) - 1)
                        @(negedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        sam_in_t     t;
        logic [15:0] digit_cfg;
        logic [15:0] blink_cfg;
        logic [7:0]  offset_cfg [3];
        logic        gappy;

        for (int i = 0; i < 3; i++)
            base_axis[i] = 8'($urandom);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings: field extremes, checkerboard
        // patterns, readings at and next to the thresholds, and button presses
        // that arrive long before the hold-off has run out and must be ignored.
        for (int k = 0; k < DIRECTED_TICKS; k++)
        begin
            t = make_tick();
            case (k)
                0: t = '{1'b1, 16'h0000, 12'h000, 8'sh00, 8'sh00, 8'sh00};
                1: t = '{1'b0, 16'hFFFF, 12'hFFF, 8'sh7F, 8'sh7F, 8'sh7F};
                2: t = '{1'b1, 16'h0000, 12'hFFF, -8'sd128, -8'sd128, -8'sd128};
                3: t = '{1'b0, 16'hFFFF, 12'h000, 8'sh7F, -8'sd128, 8'sh7F};
                4: t = '1;
                5: t = '0;
                6: t = '{1'b1, 16'hAAAA, 12'h555, 8'shAA, 8'sh55, 8'shAA};
                7: t = '{1'b0, 16'h5555, 12'hAAA, 8'sh55, 8'shAA, 8'sh55};
                8: t = '{1'b1, LIGHT_LOW_LIMIT_RST, TEMP_HIGH_LIMIT_RST,
                         8'sh00, 8'sh00, 8'sh00};
                9: t = '{1'b1, LIGHT_LOW_LIMIT_RST - 16'd1, TEMP_HIGH_LIMIT_RST + 12'd1,
                         8'sh00, 8'sh00, 8'sh00};
                default: ;
            endcase
            send_tick(t, 1'b0);
        end

        // Phases. The first mode change can only come after the hold-off, so
        // the extreme settings are placed where the block is in monitor mode.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            repeat (3)
                @(negedge clk);
            case (p)
                4:
                begin
                    // Nearly always dark and hot, any change is movement,
                    // a digit and a blink toggle on every tick.
                    light_cfg = 16'hFFFF;
                    temp_cfg  = 12'h000;
                    move_cfg  = 8'h00;
                    for (int i = 0; i < 3; i++)
                        offset_cfg[i] = 8'h80;
                    digit_cfg = 16'd1;
                    blink_cfg = 16'd1;
                end
                5:
                begin
                    // Never dark, never hot, the display frozen on its last
                    // digit, and offsets that make the corrected axes wrap.
                    light_cfg = 16'h0000;
                    temp_cfg  = 12'hFFF;
                    move_cfg  = 8'hFF;
                    for (int i = 0; i < 3; i++)
                        offset_cfg[i] = 8'h7F;
                    digit_cfg = 16'hFFFF;
                    blink_cfg = 16'hFFFF;
                end
                6:
                begin
                    light_cfg = LIGHT_LOW_LIMIT_RST;
                    temp_cfg  = TEMP_HIGH_LIMIT_RST;
                    move_cfg  = MOVE_LIMIT_RST;
                    for (int i = 0; i < 3; i++)
                        offset_cfg[i] = 8'h00;
                    digit_cfg = 16'd1;
                    blink_cfg = 16'd5;
                end
                default:
                begin
                    // Short periods so that full digit cycles and reports
                    // come around every few dozen ticks.
                    light_cfg = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 400));
                    temp_cfg  = 12'($urandom);
                    move_cfg  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 40));
                    for (int i = 0; i < 3; i++)
                        offset_cfg[i] = 8'($urandom);
                    digit_cfg = 16'($urandom_range(1, 3));
                    blink_cfg = 16'($urandom_range(1, 6));
                end
            endcase
            write_reg(REG_LIGHT_LOW_LIMIT, light_cfg, 16);
            write_reg(REG_TEMP_HIGH_LIMIT, 16'(temp_cfg), 12);
            write_reg(REG_MOVE_LIMIT, 16'(move_cfg), 8);
            write_reg(REG_X_OFFSET, 16'(offset_cfg[0]), 8);
            write_reg(REG_Y_OFFSET, 16'(offset_cfg[1]), 8);
            write_reg(REG_Z_OFFSET, 16'(offset_cfg[2]), 8);
            write_reg(REG_DIGIT_PERIOD, digit_cfg, 16);
            write_reg(REG_BLINK_PERIOD, blink_cfg, 16);

            // Some phases run back to back with no sender gaps at all.
            gappy = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < TICKS_PER_PHASE; k++)
                send_tick(make_tick(), gappy);
        end

        // Every tick yields exactly one result, so once nothing is owed the
        // block is empty; a few more cycles catch any stray result.
        drain();
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("tb_sensor_alarm_monitor: clean");
        else
            $display("tb_sensor_alarm_monitor: errors");
        $finish;
    end

endmodule
